[rtl/ssmd_pkg.sv]
// Shared types and constants of the servo slew and motor direction controller.
package ssmd_pkg;

	typedef enum logic [2:0] {
		FUNC_TICK      = 3'd0,
		FUNC_SERVO_ONE = 3'd1,
		FUNC_SERVO_TWO = 3'd2,
		FUNC_MOTOR_ONE = 3'd3,
		FUNC_MOTOR_TWO = 3'd4
	} func_t;

	typedef enum logic [2:0] {
		CFG_SERVO_ONE_MIN    = 3'd0,
		CFG_SERVO_ONE_MAX    = 3'd1,
		CFG_SERVO_TWO_MIN    = 3'd2,
		CFG_SERVO_TWO_MAX    = 3'd3,
		CFG_SERVO_ONE_PERIOD = 3'd4,
		CFG_SERVO_TWO_PERIOD = 3'd5
	} cfg_index_t;

	localparam logic [1:0] DIR_DOWN = 2'd1;
	localparam logic [1:0] DIR_HOLD = 2'd2;
	localparam logic [1:0] DIR_UP   = 2'd3;

	localparam logic [1:0] PINS_FORWARD = 2'b10;
	localparam logic [1:0] PINS_REVERSE = 2'b01;
	localparam logic [1:0] PINS_BRAKE   = 2'b11;

	localparam int DUTY_W   = 10;
	localparam int PERIOD_W = 16;
	localparam int VALUE_W  = 8;

	typedef struct packed {
		logic [DUTY_W-1:0] servo_one_duty;
		logic [DUTY_W-1:0] servo_two_duty;
		logic [1:0]        motor_one_pins;
		logic [1:0]        motor_two_pins;
	} result_t;

endpackage

[rtl/ssmd_servo.sv]
// One servo channel: tick divider, slew step with limit clamp, and direction register.
module ssmd_servo (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           tick_en,
	input  logic                           dir_we,
	input  logic [1:0]                     dir_value,
	input  logic [ssmd_pkg::DUTY_W-1:0]    lo,
	input  logic [ssmd_pkg::DUTY_W-1:0]    hi,
	input  logic [ssmd_pkg::PERIOD_W-1:0]  period,
	output logic [ssmd_pkg::DUTY_W-1:0]    position_next
);

	logic [ssmd_pkg::DUTY_W-1:0]   position_q;
	logic [1:0]                    direction_q;
	logic [ssmd_pkg::PERIOD_W-1:0] divider_q;

	logic [1:0]                    direction_next;
	logic [ssmd_pkg::PERIOD_W-1:0] divider_next;
	logic [ssmd_pkg::PERIOD_W:0]   div_sum;
	logic signed [ssmd_pkg::DUTY_W+1:0] cand;
	logic signed [ssmd_pkg::DUTY_W+1:0] lo_ext;
	logic signed [ssmd_pkg::DUTY_W+1:0] hi_ext;

	assign div_sum = {1'b0, divider_q} + {{ssmd_pkg::PERIOD_W{1'b0}}, 1'b1};
	assign cand    = signed'({2'b00, position_q}) + signed'({{ssmd_pkg::DUTY_W{1'b0}}, direction_q})
		- signed'((ssmd_pkg::DUTY_W+2)'(2));
	assign lo_ext  = signed'({2'b00, lo});
	assign hi_ext  = signed'({2'b00, hi});

	always_comb begin
		position_next  = position_q;
		direction_next = direction_q;
		divider_next   = divider_q;
		if (dir_we) begin
			direction_next = dir_value;
		end else if (tick_en) begin
			if (div_sum <= {1'b0, period}) begin
				divider_next = div_sum[ssmd_pkg::PERIOD_W-1:0];
			end else begin
				divider_next = '0;
				if (direction_q == ssmd_pkg::DIR_HOLD) begin
					position_next = '0;
				end else if (lo_ext > cand) begin
					position_next  = lo;
					direction_next = ssmd_pkg::DIR_HOLD;
				end else if (cand > hi_ext) begin
					position_next  = hi;
					direction_next = ssmd_pkg::DIR_HOLD;
				end else begin
					position_next = cand[ssmd_pkg::DUTY_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q  <= '0;
			direction_q <= ssmd_pkg::DIR_HOLD;
			divider_q   <= '0;
		end else begin
			position_q  <= position_next;
			direction_q <= direction_next;
			divider_q   <= divider_next;
		end
	end

endmodule

[rtl/ssmd_motor.sv]
// One H-bridge motor: direction code to bridge pin pair, held between commands.
module ssmd_motor (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          we,
	input  logic [ssmd_pkg::VALUE_W-1:0]  code,
	output logic [1:0]                    pins_next
);

	logic [1:0] pins_q;

	always_comb begin
		pins_next = pins_q;
		if (we) begin
			case (code)
				{6'b0, ssmd_pkg::DIR_UP}:   pins_next = ssmd_pkg::PINS_FORWARD;
				{6'b0, ssmd_pkg::DIR_DOWN}: pins_next = ssmd_pkg::PINS_REVERSE;
				{6'b0, ssmd_pkg::DIR_HOLD}: pins_next = ssmd_pkg::PINS_BRAKE;
				default:                    pins_next = pins_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pins_q <= ssmd_pkg::PINS_BRAKE;
		end else begin
			pins_q <= pins_next;
		end
	end

endmodule

[rtl/ssmd_out_buf.sv]
// Result register with a skid stage between the update logic and the output channel.
module ssmd_out_buf (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  ssmd_pkg::result_t    push_data,
	output logic                 full,
	output logic                 out_valid,
	input  logic                 out_stall,
	output ssmd_pkg::result_t    out_data
);

	logic              out_valid_q;
	logic              skid_valid_q;
	ssmd_pkg::result_t out_data_q;
	ssmd_pkg::result_t skid_data_q;
	logic              pop;

	assign pop       = out_valid_q && !out_stall;
	assign full      = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_valid_q) begin
				if (pop) begin
					skid_valid_q <= 1'b0;
				end
			end else if (push) begin
				if (!out_valid_q || pop) begin
					out_valid_q <= 1'b1;
				end else begin
					skid_valid_q <= 1'b1;
				end
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_data_q <= skid_data_q;
			end
		end else if (push) begin
			if (!out_valid_q || pop) begin
				out_data_q <= push_data;
			end else begin
				skid_data_q <= push_data;
			end
		end
	end

endmodule

[rtl/servo_slew_motor_direction_ctrl.sv]
// Top level of the two-channel servo slew and H-bridge motor direction controller.
// Each transaction on the input channel is a tick (func 0) or a direction command
// (func 1 to 4) and yields exactly one result transaction: both servo duties and both
// motor pin pairs as they stand after that update. The update is done in the cycle of
// acceptance by a compare and add per servo, so one transaction per cycle is taken
// while in_stall is low; a result register plus one skid entry let input go on while
// the output stalls; in_stall rises only when both hold results. Servo limits and
// periods are written via the cfg port (always ready) only while no transaction is
// in flight (user's duty, unchecked); a servo steps once every period plus one ticks.
module servo_slew_motor_direction_ctrl (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  func,
	input  logic [7:0]  value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [9:0]  servo_one_duty,
	output logic [9:0]  servo_two_duty,
	output logic        motor_one_pin_a,
	output logic        motor_one_pin_b,
	output logic        motor_two_pin_a,
	output logic        motor_two_pin_b,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic [ssmd_pkg::DUTY_W-1:0]   servo_one_min_q;
	logic [ssmd_pkg::DUTY_W-1:0]   servo_one_max_q;
	logic [ssmd_pkg::DUTY_W-1:0]   servo_two_min_q;
	logic [ssmd_pkg::DUTY_W-1:0]   servo_two_max_q;
	logic [ssmd_pkg::PERIOD_W-1:0] servo_one_period_q;
	logic [ssmd_pkg::PERIOD_W-1:0] servo_two_period_q;

	logic              accept;
	logic              cfg_we;
	logic              valid_dir;
	logic              full;
	ssmd_pkg::result_t result;
	ssmd_pkg::result_t out_data;

	assign accept    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;
	assign in_stall  = full;

	always_comb begin
		valid_dir = (value inside {[8'd1:8'd3]});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			servo_one_min_q    <= '0;
			servo_one_max_q    <= '0;
			servo_two_min_q    <= '0;
			servo_two_max_q    <= '0;
			servo_one_period_q <= '0;
			servo_two_period_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				ssmd_pkg::CFG_SERVO_ONE_MIN:    servo_one_min_q    <= cfg_data[9:0];
				ssmd_pkg::CFG_SERVO_ONE_MAX:    servo_one_max_q    <= cfg_data[9:0];
				ssmd_pkg::CFG_SERVO_TWO_MIN:    servo_two_min_q    <= cfg_data[9:0];
				ssmd_pkg::CFG_SERVO_TWO_MAX:    servo_two_max_q    <= cfg_data[9:0];
				ssmd_pkg::CFG_SERVO_ONE_PERIOD: servo_one_period_q <= cfg_data;
				ssmd_pkg::CFG_SERVO_TWO_PERIOD: servo_two_period_q <= cfg_data;
				default: ;
			endcase
		end
	end

	ssmd_servo u_servo_one (
		.clk           (clk),
		.arst_n        (arst_n),
		.tick_en       (accept && func == ssmd_pkg::FUNC_TICK),
		.dir_we        (accept && func == ssmd_pkg::FUNC_SERVO_ONE && valid_dir),
		.dir_value     (value[1:0]),
		.lo            (servo_one_min_q),
		.hi            (servo_one_max_q),
		.period        (servo_one_period_q),
		.position_next (result.servo_one_duty)
	);

	ssmd_servo u_servo_two (
		.clk           (clk),
		.arst_n        (arst_n),
		.tick_en       (accept && func == ssmd_pkg::FUNC_TICK),
		.dir_we        (accept && func == ssmd_pkg::FUNC_SERVO_TWO && valid_dir),
		.dir_value     (value[1:0]),
		.lo            (servo_two_min_q),
		.hi            (servo_two_max_q),
		.period        (servo_two_period_q),
		.position_next (result.servo_two_duty)
	);

	ssmd_motor u_motor_one (
		.clk       (clk),
		.arst_n    (arst_n),
		.we        (accept && func == ssmd_pkg::FUNC_MOTOR_ONE),
		.code      (value),
		.pins_next (result.motor_one_pins)
	);

	ssmd_motor u_motor_two (
		.clk       (clk),
		.arst_n    (arst_n),
		.we        (accept && func == ssmd_pkg::FUNC_MOTOR_TWO),
		.code      (value),
		.pins_next (result.motor_two_pins)
	);

	ssmd_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (result),
		.full      (full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	assign servo_one_duty  = out_data.servo_one_duty;
	assign servo_two_duty  = out_data.servo_two_duty;
	assign motor_one_pin_a = out_data.motor_one_pins[1];
	assign motor_one_pin_b = out_data.motor_one_pins[0];
	assign motor_two_pin_a = out_data.motor_two_pins[1];
	assign motor_two_pin_b = out_data.motor_two_pins[0];

endmodule
